// ----- hw/rtl/cgsp_pkg.sv -----
// Shared constants and state codes for the co-access greedy slot placer.
// No dependencies; the top level imports this package.
package cgsp_pkg;

  // Fixed field widths of the words on the ports
  localparam int KEY_W       = 12;
  localparam int STAGE_OUT_W = 3;
  localparam int REG_OUT_W   = 2;
  localparam int SLOT_W      = 12;
  localparam int CNT_W       = 13;

  // Default sizing
  localparam int NUM_KEYS_DEF   = 4096;
  localparam int NUM_STAGES_DEF = 8;
  localparam int REGS_PER_STAGE_DEF = 4;

  // Command codes
  localparam logic CMD_NEIGHBOR = 1'b0;
  localparam logic CMD_LOOKUP   = 1'b1;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_NB_RD  = 8'b0000_0100,
    S_NB_INC = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_SLOT   = 8'b0010_0000,
    S_LOOKUP = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

endpackage

// ----- hw/rtl/cgsp_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Self-contained; width and depth come from its parameters.
module cgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/coaccess_greedy_slot_placer.sv -----
// Top level of the co-access greedy slot placer; uses cgsp_pkg and three cgsp_ram instances.
// Steps: a lookup passes S_LOOKUP and S_RESULT to the output register. A neighbor word holds
// in_stall high for S_NB_RD if the neighbor is usable, then for S_NB_INC if it is placed.
// A last word then adds the scan of every register, S_SLOT and S_RESULT; a stalled output
// holds the block. One word at a time.
// Reset: all three RAMs are swept to zero while in_stall is high.
module coaccess_greedy_slot_placer #(
  parameter int NUM_KEYS         = cgsp_pkg::NUM_KEYS_DEF,
  parameter int NUM_STAGES       = cgsp_pkg::NUM_STAGES_DEF,
  parameter int REGS_PER_STAGE_P = cgsp_pkg::REGS_PER_STAGE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [cgsp_pkg::KEY_W-1:0]       in_key,
  input  logic [cgsp_pkg::KEY_W-1:0]       in_neighbor_key,
  input  logic                             in_has_neighbor,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cgsp_pkg::STAGE_OUT_W-1:0] out_stage,
  output logic [cgsp_pkg::REG_OUT_W-1:0]   out_register_index,
  output logic [cgsp_pkg::SLOT_W-1:0]      out_slot,
  output logic                             out_found,
  output logic                             out_overflow
);

  import cgsp_pkg::*;

  localparam int NUM_REGS = NUM_STAGES * REGS_PER_STAGE_P;
  localparam int KW    = $clog2(NUM_KEYS);
  localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int RW    = (REGS_PER_STAGE_P > 1) ? $clog2(REGS_PER_STAGE_P) : 1;
  localparam int IW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int ENT_W = 1 + SW + RW + SLOT_W;
  localparam int CLR_N = (NUM_KEYS > NUM_REGS) ? NUM_KEYS : NUM_REGS;
  localparam int CW    = $clog2(CLR_N);
  localparam int KX_W  = ((KW > KEY_W) ? KW : KEY_W) + 1;

  // Control registers
  state_t            state_r, state_nxt;
  logic [CW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              issued_r, issued_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;

  // Working registers
  logic [KW-1:0]     key_addr_r, key_addr_nxt;
  logic              key_ok_r, key_ok_nxt;
  logic              last_r, last_nxt;
  logic              lk_ok_r, lk_ok_nxt;
  logic [IW-1:0]     nb_idx_r, nb_idx_nxt;
  logic [IW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [SW-1:0]     scan_st_r, scan_st_nxt;
  logic [RW-1:0]     scan_rg_r, scan_rg_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [SW-1:0]     cmp_st_r, cmp_st_nxt;
  logic [RW-1:0]     cmp_rg_r, cmp_rg_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  logic [SW-1:0]     best_st_r, best_st_nxt;
  logic [RW-1:0]     best_rg_r, best_rg_nxt;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [STAGE_OUT_W-1:0] res_stage_r, res_stage_nxt, out_stage_r, out_stage_nxt;
  logic [REG_OUT_W-1:0]   res_reg_r, res_reg_nxt, out_reg_r, out_reg_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt, out_slot_r, out_slot_nxt;
  logic              res_found_r, res_found_nxt, out_found_r, out_found_nxt;
  logic              res_ovf_r, res_ovf_nxt, out_ovf_r, out_ovf_nxt;

  // RAM ports
  logic              tbl_we;
  logic [KW-1:0]     tbl_waddr, tbl_raddr;
  logic [ENT_W-1:0]  tbl_wdata, tbl_rdata;
  logic              cnt_we;
  logic [IW-1:0]     cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              slt_we;
  logic [IW-1:0]     slt_waddr, slt_raddr;
  logic [CNT_W-1:0]  slt_wdata, slt_rdata;

  // Input decode
  logic [KX_W-1:0]   key_x, nkey_x;
  logic              in_key_ok, in_nkey_ok;

  // Location entry fields
  logic              ent_valid;
  logic [SW-1:0]     ent_st;
  logic [RW-1:0]     ent_rg;
  logic [SLOT_W-1:0] ent_slot;
  logic [IW-1:0]     ent_idx;

  // Slot counter result
  logic              slot_full;
  logic [SLOT_W-1:0] slot_val;

  assign key_x      = KX_W'(in_key);
  assign nkey_x     = KX_W'(in_neighbor_key);
  assign in_key_ok  = key_x < KX_W'(NUM_KEYS);
  assign in_nkey_ok = nkey_x < KX_W'(NUM_KEYS);

  assign ent_valid = tbl_rdata[ENT_W-1];
  assign ent_st    = tbl_rdata[SW+RW+SLOT_W-1 -: SW];
  assign ent_rg    = tbl_rdata[RW+SLOT_W-1 -: RW];
  assign ent_slot  = tbl_rdata[SLOT_W-1:0];
  assign ent_idx   = IW'(IW'(ent_st) * IW'(REGS_PER_STAGE_P)) + IW'(ent_rg);

  assign slot_full = slt_rdata[SLOT_W];
  assign slot_val  = slot_full ? {SLOT_W{1'b1}} : slt_rdata[SLOT_W-1:0];

  // Read addresses: table from the input word, counts from the scan or the neighbor, slots from the best
  assign tbl_raddr = (in_command == CMD_LOOKUP) ? key_x[KW-1:0] : nkey_x[KW-1:0];
  assign cnt_raddr = (state_r == S_SCAN) ? scan_idx_r : ent_idx;
  assign slt_raddr = best_idx_nxt;

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_stage          = out_stage_r;
  assign out_register_index = out_reg_r;
  assign out_slot           = out_slot_r;
  assign out_found          = out_found_r;
  assign out_overflow       = out_ovf_r;

  cgsp_ram #(.WIDTH(ENT_W), .DEPTH(NUM_KEYS)) u_loc_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  cgsp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_REGS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  cgsp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_REGS)) u_slot_ram (
    .clk   (clk),
    .we    (slt_we),
    .waddr (slt_waddr),
    .wdata (slt_wdata),
    .raddr (slt_raddr),
    .rdata (slt_rdata)
  );

  // Next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    issued_nxt    = issued_r;
    cmp_valid_nxt = cmp_valid_r;
    key_addr_nxt  = key_addr_r;
    key_ok_nxt    = key_ok_r;
    last_nxt      = last_r;
    lk_ok_nxt     = lk_ok_r;
    nb_idx_nxt    = nb_idx_r;
    scan_idx_nxt  = scan_idx_r;
    scan_st_nxt   = scan_st_r;
    scan_rg_nxt   = scan_rg_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_st_nxt    = cmp_st_r;
    cmp_rg_nxt    = cmp_rg_r;
    best_idx_nxt  = best_idx_r;
    best_st_nxt   = best_st_r;
    best_rg_nxt   = best_rg_r;
    best_cnt_nxt  = best_cnt_r;
    res_stage_nxt = res_stage_r;
    res_reg_nxt   = res_reg_r;
    res_slot_nxt  = res_slot_r;
    res_found_nxt = res_found_r;
    res_ovf_nxt   = res_ovf_r;
    out_stage_nxt = out_stage_r;
    out_reg_nxt   = out_reg_r;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;

    tbl_we    = 1'b0;
    tbl_waddr = clr_r[KW-1:0];
    tbl_wdata = '0;
    cnt_we    = 1'b0;
    cnt_waddr = clr_r[IW-1:0];
    cnt_wdata = '0;
    slt_we    = 1'b0;
    slt_waddr = clr_r[IW-1:0];
    slt_wdata = '0;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Arm the minimum scan while outside it; best starts at register 0
    if (state_r != S_SCAN) begin
      scan_idx_nxt  = '0;
      scan_st_nxt   = '0;
      scan_rg_nxt   = '0;
      issued_nxt    = 1'b0;
      cmp_valid_nxt = 1'b0;
      best_idx_nxt  = '0;
      best_st_nxt   = '0;
      best_rg_nxt   = '0;
      best_cnt_nxt  = {CNT_W{1'b1}};
    end

    case (state_r)
      S_CLEAR: begin
        // Sweep all three RAMs to zero
        tbl_we  = ((CW + 1)'(clr_r) < (CW + 1)'(NUM_KEYS));
        cnt_we  = ((CW + 1)'(clr_r) < (CW + 1)'(NUM_REGS));
        slt_we  = cnt_we;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_LOOKUP) begin
            lk_ok_nxt = in_key_ok;
            state_nxt = S_LOOKUP;
          end else begin
            last_nxt     = in_last;
            key_addr_nxt = key_x[KW-1:0];
            key_ok_nxt   = in_key_ok;
            if (in_has_neighbor && in_nkey_ok) begin
              state_nxt = S_NB_RD;
            end else if (in_last) begin
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_LOOKUP: begin
        if (lk_ok_r && ent_valid) begin
          res_stage_nxt = STAGE_OUT_W'(ent_st);
          res_reg_nxt   = REG_OUT_W'(ent_rg);
          res_slot_nxt  = ent_slot;
          res_found_nxt = 1'b1;
        end else begin
          res_stage_nxt = '0;
          res_reg_nxt   = '0;
          res_slot_nxt  = '0;
          res_found_nxt = 1'b0;
        end
        res_ovf_nxt = 1'b0;
        state_nxt   = S_RESULT;
      end

      S_NB_RD: begin
        // Placed neighbor: fetch its register's count
        if (ent_valid) begin
          nb_idx_nxt = ent_idx;
          state_nxt  = S_NB_INC;
        end else begin
          state_nxt = last_r ? S_SCAN : S_IDLE;
        end
      end

      S_NB_INC: begin
        // Saturating increment
        if (!(&cnt_rdata)) begin
          cnt_we    = 1'b1;
          cnt_waddr = nb_idx_r;
          cnt_wdata = cnt_rdata + 1'b1;
        end
        state_nxt = last_r ? S_SCAN : S_IDLE;
      end

      S_SCAN: begin
        // Issue the next count read
        if (!issued_r) begin
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = scan_idx_r;
          cmp_st_nxt    = scan_st_r;
          cmp_rg_nxt    = scan_rg_r;
          scan_idx_nxt  = scan_idx_r + 1'b1;
          if (scan_rg_r == RW'(REGS_PER_STAGE_P - 1)) begin
            scan_rg_nxt = '0;
            scan_st_nxt = scan_st_r + 1'b1;
          end else begin
            scan_rg_nxt = scan_rg_r + 1'b1;
          end
          if (scan_idx_r == IW'(NUM_REGS - 1)) begin
            issued_nxt = 1'b1;
          end
        end else begin
          cmp_valid_nxt = 1'b0;
        end
        // Compare the returned count, keep the first minimum, clear the entry
        if (cmp_valid_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = cmp_idx_r;
          cnt_wdata = '0;
          if (cnt_rdata < best_cnt_r) begin
            best_idx_nxt = cmp_idx_r;
            best_st_nxt  = cmp_st_r;
            best_rg_nxt  = cmp_rg_r;
            best_cnt_nxt = cnt_rdata;
          end
          if (cmp_idx_r == IW'(NUM_REGS - 1)) begin
            state_nxt = S_SLOT;
          end
        end
      end

      S_SLOT: begin
        // Take the next free slot, saturating at the limit
        if (!slot_full) begin
          slt_we    = 1'b1;
          slt_waddr = best_idx_r;
          slt_wdata = slt_rdata + 1'b1;
        end
        tbl_we        = key_ok_r;
        tbl_waddr     = key_addr_r;
        tbl_wdata     = {1'b1, best_st_r, best_rg_r, slot_val};
        res_stage_nxt = STAGE_OUT_W'(best_st_r);
        res_reg_nxt   = REG_OUT_W'(best_rg_r);
        res_slot_nxt  = slot_val;
        res_found_nxt = 1'b1;
        res_ovf_nxt   = slot_full;
        state_nxt     = S_RESULT;
      end

      S_RESULT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_stage_nxt = res_stage_r;
          out_reg_nxt   = res_reg_r;
          out_slot_nxt  = res_slot_r;
          out_found_nxt = res_found_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
      cmp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r    <= issued_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    key_addr_r  <= key_addr_nxt;
    key_ok_r    <= key_ok_nxt;
    last_r      <= last_nxt;
    lk_ok_r     <= lk_ok_nxt;
    nb_idx_r    <= nb_idx_nxt;
    scan_idx_r  <= scan_idx_nxt;
    scan_st_r   <= scan_st_nxt;
    scan_rg_r   <= scan_rg_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    cmp_st_r    <= cmp_st_nxt;
    cmp_rg_r    <= cmp_rg_nxt;
    best_idx_r  <= best_idx_nxt;
    best_st_r   <= best_st_nxt;
    best_rg_r   <= best_rg_nxt;
    best_cnt_r  <= best_cnt_nxt;
    res_stage_r <= res_stage_nxt;
    res_reg_r   <= res_reg_nxt;
    res_slot_r  <= res_slot_nxt;
    res_found_r <= res_found_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_stage_r <= out_stage_nxt;
    out_reg_r   <= out_reg_nxt;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule
